// ===== rtl/vc_pkg.sv =====
// Shared types, widths and helpers for the vertical conductance core.
// No dependencies.
package vc_pkg;

   localparam int KW   = 48;  // conductivity
   localparam int TW   = 36;  // thickness
   localparam int EW   = 40;  // head / top elevation
   localparam int AW   = 40;  // area
   localparam int RW   = 16;  // config registers
   localparam int QW   = 63;  // quotient / conductance
   localparam int DW   = 100; // divisor, remainder
   localparam int NW   = 156; // dividend
   localparam int CELLS = QW;

   localparam logic [RW-1:0] WET_MARGIN_RST = 16'd100;
   localparam logic [RW-1:0] DRY_FLOOR_RST  = 16'd10;
   localparam logic [19:0]   MICRO_SCALE    = 20'd1000000;

   typedef enum logic [1:0] {
      CSR_WET_MARGIN = 2'd0,
      CSR_DRY_FLOOR  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic          valid;
      logic          zero;
      logic          ovf;
      logic [DW-1:0] rem;
      logic [DW-1:0] den;
      logic [QW-1:0] bits;
   } div_type;

   function automatic logic [TW-1:0] sat_thick(
      input logic [EW-1:0] head,
      input logic [EW-1:0] top,
      input logic [TW-1:0] thick,
      input logic [RW-1:0] margin,
      input logic [RW-1:0] floor_t
   );
      logic signed [41:0] head_x;
      logic signed [41:0] top_x;
      logic signed [41:0] bottom;
      logic signed [41:0] head_m;
      logic signed [41:0] d;
      logic [TW-1:0]      t;
      head_x = $signed({{2{head[EW-1]}}, head});
      top_x  = $signed({{2{top[EW-1]}}, top});
      bottom = top_x - $signed({6'b0, thick});
      head_m = head_x + $signed({26'b0, margin});
      d      = head_x - bottom;
      if (head_x >= top_x) begin
         t = thick;
      end else if (head_m > bottom) begin
         t = (d > 42'sd0) ? d[TW-1:0] : '0;
      end else begin
         t = '0;
      end
      if (t == '0) begin
         t = TW'(floor_t);
      end
      return t;
   endfunction

endpackage

// ===== rtl/vc_front.sv =====
// Front pipeline: saturated thickness, split products, dividend/divisor setup.
// Uses vc_pkg; feeds the first divider cell.
module vc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       load,
   output logic                       busy,
   input  logic [vc_pkg::RW-1:0]      wet_margin,
   input  logic [vc_pkg::RW-1:0]      dry_floor,
   input  logic [vc_pkg::KW-1:0]      cond_self,
   input  logic [vc_pkg::KW-1:0]      cond_neig,
   input  logic [vc_pkg::TW-1:0]      thick_self,
   input  logic [vc_pkg::TW-1:0]      thick_neig,
   input  logic [vc_pkg::EW-1:0]      level_self,
   input  logic [vc_pkg::EW-1:0]      level_neig,
   input  logic [vc_pkg::EW-1:0]      top_self,
   input  logic [vc_pkg::EW-1:0]      top_neig,
   input  logic [vc_pkg::AW-1:0]      area,
   input  logic                       is_confined,
   output vc_pkg::div_type            cell_out
);

   // stage 1
   logic                  v1_ff, z1_ff;
   logic [35:0]           ts1_ff, tn1_ff, ts1_in, tn1_in;
   logic [47:0]           ks1_ff, kn1_ff;
   logic [39:0]           a1_ff;
   // stage 2
   logic                  v2_ff, z2_ff;
   logic [59:0]           tk_lo_ff, tk_hi_ff, nk_lo_ff, nk_hi_ff, a6_2_ff;
   logic [47:0]           kk_ff [4];
   // stage 3
   logic                  v3_ff, z3_ff;
   logic [84:0]           den3_ff;
   logic [95:0]           kk3_ff;
   logic [59:0]           a6_3_ff;
   // stage 4
   logic                  v4_ff, z4_ff;
   logic [84:0]           den4_ff;
   logic [53:0]           pp_ff [8];
   // stage 5
   logic                  v5_ff, z5_ff;
   logic [vc_pkg::DW-1:0] den5_ff;
   logic [vc_pkg::NW-1:0] num5_ff;
   // stage 6
   vc_pkg::div_type       c6_ff, c6_in;
   logic [92:0]           num_hi;

   assign busy = v1_ff;

   always_comb begin
      if (is_confined) begin
         ts1_in = thick_self;
         tn1_in = thick_neig;
      end else begin
         ts1_in = vc_pkg::sat_thick(level_self, top_self, thick_self, wet_margin, dry_floor);
         tn1_in = vc_pkg::sat_thick(level_neig, top_neig, thick_neig, wet_margin, dry_floor);
      end
   end

   assign num_hi = num5_ff[vc_pkg::NW-1:vc_pkg::QW];

   always_comb begin
      c6_in.valid = v5_ff;
      c6_in.zero  = z5_ff;
      c6_in.ovf   = ({7'b0, num_hi} >= den5_ff);
      c6_in.rem   = {7'b0, num_hi};
      c6_in.den   = den5_ff;
      c6_in.bits  = num5_ff[vc_pkg::QW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (load) begin
         v1_ff <= 1'b1;
      end else if (en) begin
         v1_ff <= 1'b0;
      end
      if (load) begin
         ts1_ff <= ts1_in;
         tn1_ff <= tn1_in;
         ks1_ff <= cond_self;
         kn1_ff <= cond_neig;
         a1_ff  <= area;
         z1_ff  <= (ts1_in == '0) || (tn1_in == '0) || (cond_self == '0) ||
                   (cond_neig == '0);
      end
      if (reset) begin
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         v5_ff       <= 1'b0;
         c6_ff.valid <= 1'b0;
      end else if (en) begin
         v2_ff    <= v1_ff;
         z2_ff    <= z1_ff;
         tk_lo_ff <= 60'(ts1_ff) * 60'(kn1_ff[23:0]);
         tk_hi_ff <= 60'(ts1_ff) * 60'(kn1_ff[47:24]);
         nk_lo_ff <= 60'(tn1_ff) * 60'(ks1_ff[23:0]);
         nk_hi_ff <= 60'(tn1_ff) * 60'(ks1_ff[47:24]);
         kk_ff[0] <= 48'(ks1_ff[23:0]) * 48'(kn1_ff[23:0]);
         kk_ff[1] <= 48'(ks1_ff[23:0]) * 48'(kn1_ff[47:24]);
         kk_ff[2] <= 48'(ks1_ff[47:24]) * 48'(kn1_ff[23:0]);
         kk_ff[3] <= 48'(ks1_ff[47:24]) * 48'(kn1_ff[47:24]);
         a6_2_ff  <= 60'(a1_ff) * 60'(vc_pkg::MICRO_SCALE);

         v3_ff    <= v2_ff;
         z3_ff    <= z2_ff;
         den3_ff  <= (85'(tk_lo_ff) + 85'(nk_lo_ff)) +
                     ((85'(tk_hi_ff) + 85'(nk_hi_ff)) << 24);
         kk3_ff   <= 96'(kk_ff[0]) + ((96'(kk_ff[1]) + 96'(kk_ff[2])) << 24) +
                     (96'(kk_ff[3]) << 48);
         a6_3_ff  <= a6_2_ff;

         v4_ff    <= v3_ff;
         z4_ff    <= z3_ff;
         den4_ff  <= den3_ff;
         pp_ff[0] <= 54'(a6_3_ff[29:0]) * 54'(kk3_ff[23:0]);
         pp_ff[1] <= 54'(a6_3_ff[59:30]) * 54'(kk3_ff[23:0]);
         pp_ff[2] <= 54'(a6_3_ff[29:0]) * 54'(kk3_ff[47:24]);
         pp_ff[3] <= 54'(a6_3_ff[59:30]) * 54'(kk3_ff[47:24]);
         pp_ff[4] <= 54'(a6_3_ff[29:0]) * 54'(kk3_ff[71:48]);
         pp_ff[5] <= 54'(a6_3_ff[59:30]) * 54'(kk3_ff[71:48]);
         pp_ff[6] <= 54'(a6_3_ff[29:0]) * 54'(kk3_ff[95:72]);
         pp_ff[7] <= 54'(a6_3_ff[59:30]) * 54'(kk3_ff[95:72]);

         v5_ff    <= v4_ff;
         z5_ff    <= z4_ff;
         den5_ff  <= {den4_ff, 15'b0};
         num5_ff  <= (vc_pkg::NW'(pp_ff[0]) + (vc_pkg::NW'(pp_ff[1]) << 30)) +
                     ((vc_pkg::NW'(pp_ff[2]) << 24) + (vc_pkg::NW'(pp_ff[3]) << 54)) +
                     ((vc_pkg::NW'(pp_ff[4]) << 48) + (vc_pkg::NW'(pp_ff[5]) << 78)) +
                     ((vc_pkg::NW'(pp_ff[6]) << 72) + (vc_pkg::NW'(pp_ff[7]) << 102));

         c6_ff    <= c6_in;
      end
   end

   assign cell_out = c6_ff;

endmodule

// ===== rtl/vc_div_cell.sv =====
// One restoring-division cell: one quotient bit per cell.
// Uses vc_pkg; chained by the top level.
module vc_div_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  vc_pkg::div_type cell_in,
   output vc_pkg::div_type cell_out
);

   logic [vc_pkg::DW:0]   shifted;
   logic [vc_pkg::DW+1:0] diff;
   logic                  qbit;
   vc_pkg::div_type       cell_ff, cell_in_next;

   assign shifted = {cell_in.rem, cell_in.bits[vc_pkg::QW-1]};
   assign diff    = {1'b0, shifted} - {2'b0, cell_in.den};
   assign qbit    = ~diff[vc_pkg::DW+1];

   always_comb begin
      cell_in_next      = cell_in;
      cell_in_next.rem  = qbit ? diff[vc_pkg::DW-1:0] : shifted[vc_pkg::DW-1:0];
      cell_in_next.bits = {cell_in.bits[vc_pkg::QW-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== rtl/vertical_conductance_core.sv =====
// Vertical conductance core: front pipeline, divider cell chain, output register.
// Uses vc_pkg, vc_front, vc_div_cell.
// An accepted item passes 6 front stages (the first loaded at the accepting edge), 63 divider
// cells and 1 output register before rsp_valid rises. Throughput: one item per cycle while no result is held.
// A held result freezes the whole pipeline; an empty first stage still takes an item.
// Synchronous reset clears all valid bits and sets the registers to 100 and 10.
module vertical_conductance_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [vc_pkg::KW-1:0] req_cond_self,
   input  logic [vc_pkg::KW-1:0] req_cond_neig,
   input  logic [vc_pkg::TW-1:0] req_thick_self,
   input  logic [vc_pkg::TW-1:0] req_thick_neig,
   input  logic [vc_pkg::EW-1:0] req_level_self,
   input  logic [vc_pkg::EW-1:0] req_level_neig,
   input  logic [vc_pkg::EW-1:0] req_top_self,
   input  logic [vc_pkg::EW-1:0] req_top_neig,
   input  logic [vc_pkg::AW-1:0] req_area,
   input  logic                  req_is_confined,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [vc_pkg::QW-1:0] rsp_conductance,
   output logic                  rsp_overflowed,
   output logic                  rsp_zero_term,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [vc_pkg::RW-1:0] csr_wdata
);

   logic [vc_pkg::RW-1:0] wet_margin_ff, dry_floor_ff;
   logic                  en, load, busy;
   vc_pkg::div_type       chain [vc_pkg::CELLS+1];
   vc_pkg::div_type       last;
   logic                  rsp_valid_ff, rsp_ovf_ff, rsp_zero_ff;
   logic [vc_pkg::QW-1:0] rsp_cond_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wet_margin_ff <= vc_pkg::WET_MARGIN_RST;
         dry_floor_ff  <= vc_pkg::DRY_FLOOR_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            vc_pkg::CSR_WET_MARGIN: wet_margin_ff <= csr_wdata;
            vc_pkg::CSR_DRY_FLOOR:  dry_floor_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !(en || !busy);
   assign load      = req_valid && !req_stall;

   vc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .load        (load),
      .busy        (busy),
      .wet_margin  (wet_margin_ff),
      .dry_floor   (dry_floor_ff),
      .cond_self   (req_cond_self),
      .cond_neig   (req_cond_neig),
      .thick_self  (req_thick_self),
      .thick_neig  (req_thick_neig),
      .level_self  (req_level_self),
      .level_neig  (req_level_neig),
      .top_self    (req_top_self),
      .top_neig    (req_top_neig),
      .area        (req_area),
      .is_confined (req_is_confined),
      .cell_out    (chain[0])
   );

   for (genvar i = 0; i < vc_pkg::CELLS; i++) begin : g_cell
      vc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign last = chain[vc_pkg::CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= last.valid;
         rsp_zero_ff  <= last.zero;
         rsp_ovf_ff   <= last.ovf && !last.zero;
         if (last.zero) begin
            rsp_cond_ff <= '0;
         end else if (last.ovf) begin
            rsp_cond_ff <= '1;
         end else begin
            rsp_cond_ff <= last.bits;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_conductance = rsp_cond_ff;
   assign rsp_overflowed  = rsp_ovf_ff;
   assign rsp_zero_term   = rsp_zero_ff;

endmodule
